FILE: design/bval_pkg.sv
// Shared types and constants for the battery voltage average level unit.
// No dependencies; imported by the interfaces and the top level.
package bval_pkg;

  // Widths of the millivolt and level fields
  localparam int MV_W    = 13;
  localparam int LEVEL_W = 3;

  // Default window length (samples averaged)
  localparam int WINDOW_LEN_DEF = 20;

  // Configuration registers: five ascending thresholds
  localparam int NUM_THRESH = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = MV_W;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESH_ONE   = 3'd0,
    REG_THRESH_TWO   = 3'd1,
    REG_THRESH_THREE = 3'd2,
    REG_THRESH_FOUR  = 3'd3,
    REG_THRESH_FIVE  = 3'd4
  } reg_index_t;

  // Threshold reset values, entry 0 is threshold one
  localparam logic [NUM_THRESH-1:0][MV_W-1:0] TH_RESET = {
    13'd4034, 13'd3831, 13'd3733, 13'd3535, 13'd3370
  };

  // Result status codes
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_ABSENT = 1'b1;

  // Level reported as full
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 3'd5;

endpackage

FILE: design/bval_if.sv
// Valid/ready channel interfaces: voltage sample in, level result out.
// Depends on bval_pkg.

interface bval_sample_if
  import bval_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [MV_W-1:0] sample_mv;
  logic            battery_present;

  modport source (output valid, output sample_mv, output battery_present, input ready);
  modport sink   (input valid, input sample_mv, input battery_present, output ready);
endinterface

interface bval_result_if
  import bval_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               status;
  logic [LEVEL_W-1:0] level;
  logic               is_full;
  logic [MV_W-1:0]    average_mv;

  modport source (output valid, output status, output level, output is_full,
                  output average_mv, input ready);
  modport sink   (input valid, input status, input level, input is_full,
                  input average_mv, output ready);
endinterface

FILE: design/battery_voltage_average_level_unit.sv
// Battery voltage sliding-window average with threshold level quantizer.
// Depends on bval_pkg and the channel interfaces in bval_if.sv.
//
//   channel  dir  beat contents
//   samp     in   sample_mv, battery_present
//   res      out  status, level, is_full, average_mv
//   cfg      in   cfg_we, cfg_index, cfg_data (threshold writes)
//
// A present sample passes through the update state, then the bit-serial restoring
// divider, which forms total / fill count one quotient bit per cycle, then the
// final state that loads the output register. An absent battery skips to the
// final state for its error result. samp.ready is high only while idle.
// A finished result sits in the output register until taken; the next sample
// is accepted meanwhile and its result waits in the final state if needed.
// Reset restores the thresholds and empties the window; no clearing pass.
module battery_voltage_average_level_unit
  import bval_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  bval_sample_if.sink           samp,
  bval_result_if.source         res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int TOT_W = MV_W + $clog2(WINDOW_LEN);
  localparam int CYC_W = $clog2(TOT_W + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_UPDATE = 4'b0010,
    S_DIV    = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Threshold registers
  logic [MV_W-1:0] thr [NUM_THRESH];

  // Window storage: circular buffer, wr_ptr is the oldest entry when full
  logic [MV_W-1:0]  window_mem [WINDOW_LEN];
  logic [MV_W-1:0]  oldest;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] fill_count;
  logic [TOT_W-1:0] running_total;
  logic             full;

  // Item registers
  logic [MV_W-1:0]  sample;
  logic             absent;

  // Divider registers
  logic [TOT_W-1:0] quo;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] divisor;
  logic [CYC_W-1:0] div_cnt;

  logic [CNT_W+1:0] trial;
  logic             trial_neg;
  logic [TOT_W-1:0] total_next;
  logic [CNT_W-1:0] fill_next;
  logic [MV_W-1:0]  avg;
  logic [LEVEL_W-1:0] lvl;
  logic             samp_beat;
  logic             out_free;

  assign full      = (fill_count == CNT_W'(WINDOW_LEN));
  assign samp_beat = samp.valid && samp.ready;
  assign out_free  = !res.valid || res.ready;
  assign samp.ready = (state == S_IDLE);

  // Threshold writes, indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_THRESH; i++) thr[i] <= TH_RESET[i];
    end else if (cfg_we && cfg_index <= REG_THRESH_FIVE) begin
      thr[cfg_index] <= cfg_data;
    end
  end

  // Window memory: registered read of the oldest slot, write of the new sample
  always_ff @(posedge clk) begin
    oldest <= window_mem[wr_ptr];
    if (state == S_UPDATE) begin
      window_mem[wr_ptr] <= sample;
    end
  end

  // New total and fill count after the push
  always_comb begin
    total_next = running_total + TOT_W'(sample) - (full ? TOT_W'(oldest) : '0);
    fill_next  = full ? fill_count : fill_count + CNT_W'(1);
  end

  // One restoring divide step
  always_comb begin
    trial     = {1'b0, rem, quo[TOT_W-1]} - {2'b00, divisor};
    trial_neg = trial[CNT_W+1];
  end

  // Level quantizer: highest threshold reached wins
  assign avg = quo[MV_W-1:0];
  always_comb begin
    lvl = '0;
    for (int k = 0; k < NUM_THRESH; k++) begin
      if (avg >= thr[k]) lvl = LEVEL_W'(k + 1);
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (samp_beat) state_next = samp.battery_present ? S_UPDATE : S_DONE;
      end
      S_UPDATE: state_next = S_DIV;
      S_DIV: begin
        if (div_cnt == CYC_W'(1)) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      fill_count    <= '0;
      running_total <= '0;
      wr_ptr        <= '0;
    end else begin
      state <= state_next;
      if (state == S_UPDATE) begin
        running_total <= total_next;
        fill_count    <= fill_next;
        wr_ptr        <= (wr_ptr == PTR_W'(WINDOW_LEN - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
    end
  end

  // Item capture and divider datapath
  always_ff @(posedge clk) begin
    if (samp_beat) begin
      sample <= samp.sample_mv;
      absent <= !samp.battery_present;
    end
    if (state == S_UPDATE) begin
      quo     <= total_next;
      rem     <= '0;
      divisor <= fill_next;
      div_cnt <= CYC_W'(TOT_W);
    end else if (state == S_DIV) begin
      quo     <= {quo[TOT_W-2:0], !trial_neg};
      rem     <= trial_neg ? {rem[CNT_W-2:0], quo[TOT_W-1]} : trial[CNT_W-1:0];
      div_cnt <= div_cnt - CYC_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      if (absent) begin
        res.status     <= STATUS_ABSENT;
        res.level      <= '0;
        res.is_full    <= 1'b0;
        res.average_mv <= '0;
      end else begin
        res.status     <= STATUS_OK;
        res.level      <= lvl;
        res.is_full    <= (lvl == LEVEL_FULL);
        res.average_mv <= avg;
      end
    end
  end

endmodule

FILE: verif/battery_voltage_average_level_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for battery_voltage_average_level_unit: sliding-window average and level.
// Depends on bval_pkg, the channel interfaces in bval_if.sv and the unit itself.
module battery_voltage_average_level_unit_test;
  import bval_pkg::*;

  localparam int MV_MAX = (1 << MV_W) - 1;
  localparam int IDLE_PCT = 6;
  localparam int TIMEOUT_NS = 2_000_000;
  localparam int TAIL_CYCLES = 32;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_SPARE = CFG_IDX_W'(NUM_THRESH);
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_TOP = {CFG_IDX_W{1'b1}};

  typedef struct packed {
    logic [MV_W-1:0] sample_mv;
    logic            battery_present;
  } sample_beat_t;

  typedef struct packed {
    logic               status;
    logic [LEVEL_W-1:0] level;
    logic               is_full;
    logic [MV_W-1:0]    average_mv;
  } level_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bval_sample_if samp_ch ();
  bval_result_if res_ch ();

  battery_voltage_average_level_unit dut (
    .clk       (clk),
    .rst       (rst),
    .samp      (samp_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Stimulus backlog, predicted results, predictor state
  sample_beat_t    sample_backlog[$];
  level_result_t   pending_levels[$];
  logic [MV_W-1:0] voltage_window[$];
  logic [MV_W-1:0] th_shadow[NUM_THRESH];
  logic [MV_W-1:0] th_plan[NUM_THRESH];
  logic            samp_beat;
  logic            calm;
  int              mismatch_count;
  int              center_mv;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Highest threshold reached, searched from the top down
  function automatic logic [LEVEL_W-1:0] grade_level(int avg);
    for (int k = NUM_THRESH; k > 0; k--) begin
      if (avg >= th_shadow[k-1]) return k[LEVEL_W-1:0];
    end
    return '0;
  endfunction

  // Push into the window and average; an absent battery leaves it alone
  function automatic level_result_t average_and_grade(logic [MV_W-1:0] mv, logic present);
    level_result_t r;
    int total;
    int avg;
    r = '0;
    if (!present) begin
      r.status = STATUS_ABSENT;
      return r;
    end
    voltage_window.push_back(mv);
    if (voltage_window.size() > WINDOW_LEN_DEF) void'(voltage_window.pop_front());
    total = 0;
    foreach (voltage_window[i]) total += voltage_window[i];
    avg = total / voltage_window.size();
    r.status     = STATUS_OK;
    r.average_mv = avg[MV_W-1:0];
    r.level      = grade_level(avg);
    r.is_full    = (r.level == LEVEL_FULL);
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Track register writes and predict each accepted sample beat
  always @(posedge clk) begin
    if (rst) begin
      voltage_window.delete();
      for (int i = 0; i < NUM_THRESH; i++) th_shadow[i] = TH_RESET[i];
      samp_beat <= 1'b0;
    end else begin
      if (cfg_we && cfg_index < NUM_THRESH) th_shadow[cfg_index] = cfg_data;
      samp_beat <= samp_ch.valid && samp_ch.ready;
      if (samp_ch.valid && samp_ch.ready) begin
        pending_levels.push_back(average_and_grade(samp_ch.sample_mv, samp_ch.battery_present));
        void'(sample_backlog.pop_front());
      end
    end
  end

  // Driver: hold an offered beat until taken, otherwise offer the next one
  always @(negedge clk) begin
    if (rst) begin
      samp_ch.valid <= 1'b0;
    end else if (!samp_ch.valid || samp_beat) begin
      if (sample_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        samp_ch.valid           <= 1'b1;
        samp_ch.sample_mv       <= sample_backlog[0].sample_mv;
        samp_ch.battery_present <= sample_backlog[0].battery_present;
      end else begin
        samp_ch.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    res_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin : result_monitor
    level_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_levels.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d level %0d",
                 $time, res_ch.status, res_ch.level);
        $display("%0t: unexpected result: actual full %0d avg %0d",
                 $time, res_ch.is_full, res_ch.average_mv);
        mismatch_count++;
      end else begin
        want = pending_levels.pop_front();
        check_field("status", int'(want.status), int'(res_ch.status));
        check_field("level", int'(want.level), int'(res_ch.level));
        check_field("is_full", int'(want.is_full), int'(res_ch.is_full));
        check_field("average_mv", int'(want.average_mv), int'(res_ch.average_mv));
      end
    end
  end

  task automatic push_item(int mv, logic present);
    sample_beat_t b;
    b.sample_mv       = mv[MV_W-1:0];
    b.battery_present = present;
    sample_backlog.push_back(b);
  endtask

  // Random beats: a drifting battery voltage with noise, full-range and rail values
  task automatic queue_random(int count);
    int pick;
    int mv;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      center_mv += int'($urandom_range(0, 300)) - 150;
      if (center_mv < 2800) center_mv = 2800;
      if (center_mv > 4600) center_mv = 4600;
      if (pick < 70) mv = center_mv + int'($urandom_range(0, 200)) - 100;
      else if (pick < 90) mv = $urandom_range(0, MV_MAX);
      else mv = pick[0] ? MV_MAX : 0;
      push_item(mv, pick >= 10);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_plan();
    for (int i = 0; i < NUM_THRESH; i++) write_reg(i[CFG_IDX_W-1:0], th_plan[i]);
  endtask

  // Idle once every beat has been taken and every result has come back
  task automatic drain();
    do @(negedge clk); while (sample_backlog.size() != 0 || pending_levels.size() != 0);
  endtask

  initial begin
    int base;
    int step;
    rst                     = 1'b1;
    cfg_we                  = 1'b0;
    cfg_index               = '0;
    cfg_data                = '0;
    samp_ch.valid           = 1'b0;
    samp_ch.sample_mv       = '0;
    samp_ch.battery_present = 1'b0;
    res_ch.ready            = 1'b0;
    calm                    = 1'b0;
    mismatch_count          = 0;
    center_mv               = 3700;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: absent on an empty window, rails, threshold edges at reset values
    push_item(0, 1'b0);
    push_item(MV_MAX, 1'b0);
    push_item(MV_MAX, 1'b1);
    push_item(0, 1'b1);
    push_item(0, 1'b1);
    push_item(3370, 1'b1);
    push_item(3535, 1'b1);
    push_item(3733, 1'b1);
    push_item(3831, 1'b1);
    push_item(4034, 1'b1);
    push_item(4237, 1'b1);
    push_item(4300, 1'b1);
    push_item(3369, 1'b1);
    push_item(4000, 1'b0);
    push_item(5000, 1'b1);
    push_item(6826, 1'b1);
    push_item(1365, 1'b1);
    push_item(4095, 1'b1);
    push_item(4096, 1'b1);
    push_item(3000, 1'b1);
    push_item(6826, 1'b0);
    push_item(MV_MAX, 1'b1);
    push_item(MV_MAX, 1'b1);
    push_item(MV_MAX, 1'b1);
    drain();

    // All thresholds at zero: every present sample is full
    for (int i = 0; i < NUM_THRESH; i++) th_plan[i] = '0;
    write_plan();
    queue_random(150);
    drain();

    // All thresholds at the top; spare indexes must not land anywhere
    for (int i = 0; i < NUM_THRESH; i++) th_plan[i] = MV_MAX[MV_W-1:0];
    write_plan();
    write_reg(REG_INDEX_SPARE, '0);
    write_reg(REG_INDEX_TOP, '0);
    repeat (WINDOW_LEN_DEF + 1) push_item(MV_MAX, 1'b1);
    queue_random(130);
    drain();

    // Thresholds in random order
    repeat (2) begin
      for (int i = 0; i < NUM_THRESH; i++) th_plan[i] = MV_W'($urandom_range(3000, 4500));
      write_plan();
      queue_random(125);
      drain();
    end

    // Ascending random bands, one phase without any idling
    for (int p = 0; p < 6; p++) begin
      base = $urandom_range(3000, 3600);
      step = $urandom_range(50, 250);
      for (int i = 0; i < NUM_THRESH; i++) th_plan[i] = MV_W'(base + i * step);
      write_plan();
      calm = (p == 2);
      queue_random(190);
      drain();
      calm = 1'b0;
    end

    // Back to the reset thresholds
    for (int i = 0; i < NUM_THRESH; i++) th_plan[i] = TH_RESET[i];
    write_plan();
    queue_random(100);
    drain();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("** battery_voltage_average_level_unit: PASSED **");
    end else begin
      $display("** battery_voltage_average_level_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #TIMEOUT_NS;
    $display("** battery_voltage_average_level_unit: FAILED **");
    $finish;
  end

endmodule

FILE: sim.f
design/bval_pkg.sv
design/bval_if.sv
design/battery_voltage_average_level_unit.sv
verif/battery_voltage_average_level_unit_test.sv
